// ===== design/ap2d_pkg.sv =====
`default_nettype none
package ap2d_pkg;
    localparam int NUM_REGS = 8;
    localparam logic [2:0] REG_IN_ROWS     = 3'd0;
    localparam logic [2:0] REG_IN_COLS     = 3'd1;
    localparam logic [2:0] REG_KERNEL_ROWS = 3'd2;
    localparam logic [2:0] REG_KERNEL_COLS = 3'd3;
    localparam logic [2:0] REG_STRIDE_ROWS = 3'd4;
    localparam logic [2:0] REG_STRIDE_COLS = 3'd5;
    localparam logic [2:0] REG_OUT_ROWS    = 3'd6;
    localparam logic [2:0] REG_OUT_COLS    = 3'd7;
    localparam int MAX_IN_ROWS = 4096;
endpackage
`default_nettype wire

// ===== design/ap2d_ram.sv =====
`default_nettype none
module ap2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/average_pooling_2d_unit.sv =====
`default_nettype none
// Channel   Dir  Payload
// s_axis    in   tdata[15:0] sample
// m_axis    out  tdata[15:0] average, [27:16] out_row, [35:28] out_col, [39:36] zero;
//                tlast channel_done
// cfg       in   cfg_index[2:0], cfg_data[12:0]
// A sample at or past the kernel corner, with nonzero output sizes, stalls the input
// for a stride grid check; if it closes an emitted window, the window is read and
// summed, then divided and its sign fixed, and the result is held until its transfer.
// Reset clears position and state and loads default sizes; the datapath registers and
// the line store are not cleared. Configuration and samples are taken only while idle.
module average_pooling_2d_unit #(
    parameter int MAX_COLS    = 256,
    parameter int MAX_KERNEL  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [SAMPLE_BITS-1:0] s_axis_tdata,   // sample
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [SAMPLE_BITS+23:0]     m_axis_tdata,   // average, out_row, out_col, zero
    output logic                        m_axis_tlast,   // channel_done
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [12:0]            cfg_data
);
    import ap2d_pkg::*;

    localparam int CB = $clog2(MAX_COLS);
    localparam int KB = $clog2(MAX_KERNEL);
    localparam int AB = CB + KB;
    localparam int KAB = 2 * $clog2(MAX_KERNEL + 1);
    localparam int SB = SAMPLE_BITS + KAB;
    localparam int QB = 6;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [12:0] in_rows_reg, in_cols_reg, out_rows_reg, out_cols_reg;
    logic [3:0]  kr_reg, kc_reg, sr_reg, sc_reg;
    logic [12:0] row_reg;
    logic [12:0] col_reg;
    logic [1:0]  state_reg;

    // clamped sizes
    logic [12:0] rows, cols;
    logic [4:0]  kr, kc, sr, sc;
    always_comb
    begin
        rows = (in_rows_reg == 13'd0) ? 13'd1 :
               (in_rows_reg > 13'(MAX_IN_ROWS)) ? 13'(MAX_IN_ROWS) : in_rows_reg;
        cols = (in_cols_reg == 13'd0) ? 13'd1 :
               (in_cols_reg > 13'(MAX_COLS)) ? 13'(MAX_COLS) : in_cols_reg;
        kr = (kr_reg == 4'd0) ? 5'd1 :
             ({1'b0, kr_reg} > 5'(MAX_KERNEL)) ? 5'(MAX_KERNEL) : {1'b0, kr_reg};
        kc = (kc_reg == 4'd0) ? 5'd1 :
             ({1'b0, kc_reg} > 5'(MAX_KERNEL)) ? 5'(MAX_KERNEL) : {1'b0, kc_reg};
        sr = (sr_reg == 4'd0) ? 5'd1 : {1'b0, sr_reg};
        sc = (sc_reg == 4'd0) ? 5'd1 : {1'b0, sc_reg};
    end

    // position with pre-wrap against the current sizes
    logic [12:0] r_now, c_now, c0, r0;
    always_comb
    begin
        c0 = col_reg;
        r0 = row_reg;
        if (c0 >= cols)
        begin
            c0 = '0;
            r0 = r0 + 13'd1;
        end
        if (r0 >= rows)
        begin
            r0 = '0;
        end
        r_now = r0;
        c_now = c0;
    end

    // window top-left offsets and corner checks
    logic [12:0] tr, tc;
    logic        row_ok, col_ok;
    logic [4:0]  grid_step_reg;

    assign tr = r_now + 13'd1 - 13'(kr);
    assign tc = c_now + 13'd1 - 13'(kc);
    assign row_ok = (r_now + 13'd1 >= 13'(kr));
    assign col_ok = (c_now + 13'd1 >= 13'(kc));

    // line store
    logic              we;
    logic [AB-1:0]     waddr, raddr;
    logic [SAMPLE_BITS-1:0] rdata;
    ap2d_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_COLS * MAX_KERNEL)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(s_axis_tdata),
        .raddr(raddr), .rdata(rdata)
    );

    // sum sequencer
    logic [KB-1:0] i_reg, j_reg;
    logic [12:0]   wr_reg, wc_reg;
    logic          rd_pend_reg, last_rd_reg;
    logic signed [SB-1:0] sum_reg;
    logic [SB-1:0] rem_reg, quo_reg, dmag;
    logic          neg_reg;
    logic [QB-1:0] dcnt_reg;
    logic [KAB-1:0] area;
    logic [11:0]   orow_reg;
    logic [7:0]    ocol_reg;
    logic          done_reg;
    logic [1:0]    gphase_reg;

    assign area = KAB'(KAB'(kr) * KAB'(kc));
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata = {4'd0, ocol_reg, orow_reg, quo_reg[SAMPLE_BITS-1:0]};
    assign m_axis_tlast = done_reg;
    assign we = s_axis_tvalid && s_axis_tready;
    assign waddr = {r_now[KB-1:0], c_now[CB-1:0]};
    assign raddr = {KB'(wr_reg + 13'(i_reg)), CB'(wc_reg + 13'(j_reg))};
    assign dmag = sum_reg[SB-1] ? SB'(-sum_reg) : SB'(sum_reg);

    // division of grid offsets by stride: restoring, 13 steps, run in ST_SUM
    // window count n = min((in-k)/s+1, out); done by the same stepper
    logic [12:0] gnum [4];
    logic [4:0]  gden [4];
    always_comb
    begin
        gnum[0] = tr;
        gnum[1] = tc;
        gnum[2] = rows - 13'(kr);
        gnum[3] = cols - 13'(kc);
        gden[0] = sr;
        gden[1] = sc;
        gden[2] = sr;
        gden[3] = sc;
    end
    logic [12:0] gq_reg [4];
    logic [12:0] gr_reg [4];
    logic [13:0] gtry [4];
    always_comb
    begin
        for (int g = 0; g < 4; g++)
        begin
            gtry[g] = {gr_reg[g], gq_reg[g][12]} - {9'd0, gden[g]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_rows_reg <= 13'd8; in_cols_reg <= 13'd8;
            kr_reg <= 4'd2; kc_reg <= 4'd2; sr_reg <= 4'd2; sc_reg <= 4'd2;
            out_rows_reg <= 13'd4; out_cols_reg <= 13'd4;
            row_reg <= '0; col_reg <= '0;
            state_reg <= ST_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    // take a configuration write
                    if (cfg_valid)
                    begin
                        case (cfg_index)
                            REG_IN_ROWS:     in_rows_reg  <= cfg_data;
                            REG_IN_COLS:     in_cols_reg  <= {4'd0, cfg_data[8:0]};
                            REG_KERNEL_ROWS: kr_reg       <= cfg_data[3:0];
                            REG_KERNEL_COLS: kc_reg       <= cfg_data[3:0];
                            REG_STRIDE_ROWS: sr_reg       <= cfg_data[3:0];
                            REG_STRIDE_COLS: sc_reg       <= cfg_data[3:0];
                            REG_OUT_ROWS:    out_rows_reg <= cfg_data;
                            default:         out_cols_reg <= {4'd0, cfg_data[8:0]};
                        endcase
                    end
                    // take a sample transfer, advance position
                    if (we)
                    begin
                        if (c_now + 13'd1 >= cols)
                        begin
                            col_reg <= '0;
                            row_reg <= (r_now + 13'd1 >= rows) ? 13'd0 : r_now + 13'd1;
                        end
                        else
                        begin
                            col_reg <= c_now + 13'd1;
                            row_reg <= r_now;
                        end
                        if (row_ok && col_ok && out_rows_reg != 13'd0 && out_cols_reg != 13'd0)
                        begin
                            state_reg <= ST_SUM;
                        end
                    end
                end
                ST_SUM:
                begin
                    // grid check, then sum
                    if (gphase_reg == 2'd2)
                    begin
                        if (gr_reg[0] != 13'd0 || gr_reg[1] != 13'd0 ||
                            gq_reg[0] >= out_rows_reg || gq_reg[1] >= out_cols_reg ||
                            gq_reg[0] > gq_reg[2] || gq_reg[1] > gq_reg[3])
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    if (gphase_reg == 2'd3 && last_rd_reg && !rd_pend_reg)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (dcnt_reg == QB'(SB + 1))
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                default:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // datapath: grid divide, window read, sum, divide
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                wr_reg <= tr;
                wc_reg <= tc;
                i_reg <= '0;
                j_reg <= '0;
                rd_pend_reg <= 1'b0;
                last_rd_reg <= 1'b0;
                sum_reg <= '0;
                gphase_reg <= 2'd0;
                grid_step_reg <= '0;
                for (int g = 0; g < 4; g++)
                begin
                    gq_reg[g] <= gnum[g];
                    gr_reg[g] <= '0;
                end
            end
            ST_SUM:
            begin
                if (gphase_reg == 2'd0)
                begin
                    for (int g = 0; g < 4; g++)
                    begin
                        if (!gtry[g][13])
                        begin
                            gr_reg[g] <= gtry[g][12:0];
                            gq_reg[g] <= {gq_reg[g][11:0], 1'b1};
                        end
                        else
                        begin
                            gr_reg[g] <= {gr_reg[g][11:0], gq_reg[g][12]};
                            gq_reg[g] <= {gq_reg[g][11:0], 1'b0};
                        end
                    end
                    grid_step_reg <= grid_step_reg + 5'd1;
                    if (grid_step_reg == 5'd12)
                    begin
                        gphase_reg <= 2'd2;
                    end
                end
                else if (gphase_reg == 2'd2)
                begin
                    orow_reg <= gq_reg[0][11:0];
                    ocol_reg <= gq_reg[1][7:0];
                    done_reg <= (gq_reg[0] == ((gq_reg[2] + 13'd1 < out_rows_reg) ?
                                 gq_reg[2] : out_rows_reg - 13'd1)) &&
                                (gq_reg[1] == ((gq_reg[3] + 13'd1 < out_cols_reg) ?
                                 gq_reg[3] : out_cols_reg - 13'd1));
                    gphase_reg <= 2'd3;
                end
                else
                begin
                    // issue one read a cycle; accumulate each read's data from the registered read port
                    if (rd_pend_reg)
                    begin
                        sum_reg <= sum_reg + SB'(signed'(rdata));
                    end
                    rd_pend_reg <= !last_rd_reg;
                    if (!last_rd_reg)
                    begin
                        if (5'(j_reg) + 5'd1 >= kc)
                        begin
                            j_reg <= '0;
                            i_reg <= i_reg + 1'b1;
                            last_rd_reg <= (5'(i_reg) + 5'd1 >= kr);
                        end
                        else
                        begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                    rem_reg <= '0;
                    dcnt_reg <= '0;
                end
            end
            ST_DIV:
            begin
                // restoring divide of the magnitude, one bit a cycle, then restore the sign
                if (dcnt_reg == 6'd0)
                begin
                    neg_reg <= sum_reg[SB-1];
                    quo_reg <= dmag;
                    rem_reg <= '0;
                    dcnt_reg <= 6'd1;
                end
                else if (dcnt_reg <= QB'(SB))
                begin
                    if ({rem_reg[SB-2:0], quo_reg[SB-1]} >= SB'(area))
                    begin
                        rem_reg <= {rem_reg[SB-2:0], quo_reg[SB-1]} - SB'(area);
                        quo_reg <= {quo_reg[SB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[SB-2:0], quo_reg[SB-1]};
                        quo_reg <= {quo_reg[SB-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg + 6'd1;
                end
                else
                begin
                    if (neg_reg)
                    begin
                        quo_reg <= -quo_reg;
                        neg_reg <= 1'b0;
                    end
                end
            end
            default:
            begin
                // hold the result until its transfer
            end
        endcase
    end
endmodule
`default_nettype wire
